// ----- rtl/core/bptc_pkg.sv -----
`default_nettype none

package bptc_pkg;

   // port field widths
   localparam int RAW_W       = 24;
   localparam int COEF_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int TEMP_W      = 15;
   localparam int PRES_W      = 17;

   // internal widths, sized for the full input and coefficient range
   localparam int DT_W     = 25;
   localparam int PROD_W   = 42;
   localparam int TEMPF_W  = 19;
   localparam int DEVL_W   = 20;
   localparam int OFF_W    = 36;
   localparam int SENS_W   = 35;
   localparam int T2_W     = 18;
   localparam int T_W      = 20;
   localparam int SQ_W     = 35;
   localparam int CORR_W   = 40;
   localparam int OFFC_W   = 41;
   localparam int SENSC_W  = 41;
   localparam int SPLIT_W  = 21;
   localparam int PL_W     = RAW_W + SPLIT_W;
   localparam int PH_W     = RAW_W + 1 + SENSC_W - SPLIT_W;
   localparam int Q_W      = PH_W + 1;
   localparam int X_W      = Q_W + 1;
   localparam int P_W      = 32;

   // shift amounts of the compensation formulas
   localparam int TEMP_SHIFT  = 23;
   localparam int OFF_SHIFT   = 7;
   localparam int SENS_SHIFT  = 8;
   localparam int T2_SHIFT    = 31;
   localparam int P_OUT_SHIFT = 15;

   // temperature thresholds and output ranges
   localparam int TEMP_REF = 2000;
   localparam int TEMP_LOW = -1500;
   localparam int T_MIN    = -4000;
   localparam int T_MAX    = 8500;
   localparam int P_MIN    = 1000;
   localparam int P_MAX    = 120000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESSURE_SENS   = 3'd0,
      CSR_PRESSURE_OFFSET = 3'd1,
      CSR_TCS             = 3'd2,
      CSR_TCO             = 3'd3,
      CSR_TREF            = 3'd4,
      CSR_TEMPSENS        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] pressure_raw;
      logic [RAW_W-1:0] temperature_raw;
   } req_payload_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [PRES_W-1:0]        pressure;
      logic                     out_of_range;
   } rsp_payload_type;

   typedef struct packed {
      logic [COEF_W-1:0] pressure_sens;
      logic [COEF_W-1:0] pressure_offset;
      logic [COEF_W-1:0] tcs;
      logic [COEF_W-1:0] tco;
      logic [COEF_W-1:0] tref;
      logic [COEF_W-1:0] tempsens;
   } coef_type;

   // first-order results handed to the second-order stages
   typedef struct packed {
      logic [RAW_W-1:0]          d1;
      logic signed [TEMPF_W-1:0] temp;
      logic signed [TEMPF_W-1:0] dev_ref;
      logic signed [DEVL_W-1:0]  dev_low;
      logic signed [OFF_W-1:0]   off;
      logic signed [SENS_W-1:0]  sens;
      logic [T2_W-1:0]           t2;
      logic                      below_ref;
      logic                      below_low;
   } fo_type;

   // corrected terms handed to the pressure stages
   typedef struct packed {
      logic [RAW_W-1:0]          d1;
      logic signed [T_W-1:0]     t;
      logic signed [OFFC_W-1:0]  off_c;
      logic signed [SENSC_W-1:0] sens_c;
   } so_type;

endpackage

`default_nettype wire

// ----- rtl/core/bptc_coef_regs.sv -----
`default_nettype none

module bptc_coef_regs import bptc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]      csr_wdata,
   output coef_type                    coef
);

   coef_type coef_ff, coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PRESSURE_SENS:   coef_in.pressure_sens   = csr_wdata;
            CSR_PRESSURE_OFFSET: coef_in.pressure_offset = csr_wdata;
            CSR_TCS:             coef_in.tcs             = csr_wdata;
            CSR_TCO:             coef_in.tco             = csr_wdata;
            CSR_TREF:            coef_in.tref            = csr_wdata;
            CSR_TEMPSENS:        coef_in.tempsens        = csr_wdata;
            default:             coef_in                 = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bptc_first_order.sv -----
`default_nettype none

module bptc_first_order import bptc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_stall,
   input  wire req_payload_type in_data,
   input  wire coef_type        coef,
   output logic                 out_valid,
   input  wire logic            out_stall,
   output fo_type               out_data
);

   logic [2:0] vld_ff, vld_in, vld_up;
   logic [3:0] stl;

   // stage 1: temperature difference
   logic [RAW_W-1:0]       d1_s1_ff;
   logic signed [DT_W-1:0] dt_s1_ff, dt_s1_in;

   // stage 2: products with the coefficients
   logic [RAW_W-1:0]                   d1_s2_ff;
   logic signed [PROD_W-TEMP_SHIFT-1:0] temp_part_ff;
   logic signed [PROD_W-OFF_SHIFT-1:0]  off_part_ff;
   logic signed [PROD_W-SENS_SHIFT-1:0] sens_part_ff;
   logic [T2_W-1:0]                    t2_ff;
   logic signed [PROD_W-1:0]           prod_t, prod_off, prod_sens;
   logic signed [2*DT_W-1:0]           dt_sq;
   logic signed [COEF_W:0]             c3_s, c4_s, c6_s;

   // stage 3: first-order terms
   fo_type fo_ff, fo_in;

   always_comb begin
      stl[3] = out_stall;
      stl[2] = vld_ff[2] & stl[3];
      stl[1] = vld_ff[1] & stl[2];
      stl[0] = vld_ff[0] & stl[1];
      vld_up = {vld_ff[1:0], in_valid};
      for (int k = 0; k < 3; k++) begin
         vld_in[k] = stl[k] ? vld_ff[k] : vld_up[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      dt_s1_in = $signed({1'b0, in_data.temperature_raw})
               - $signed({1'b0, coef.tref, 8'h00});
   end

   always_ff @(posedge clock) begin
      if (!stl[0]) begin
         d1_s1_ff <= in_data.pressure_raw;
         dt_s1_ff <= dt_s1_in;
      end
   end

   always_comb begin
      c3_s      = $signed({1'b0, coef.tcs});
      c4_s      = $signed({1'b0, coef.tco});
      c6_s      = $signed({1'b0, coef.tempsens});
      prod_t    = PROD_W'(dt_s1_ff) * PROD_W'(c6_s);
      prod_off  = PROD_W'(c4_s) * PROD_W'(dt_s1_ff);
      prod_sens = PROD_W'(c3_s) * PROD_W'(dt_s1_ff);
      dt_sq     = (2*DT_W)'(dt_s1_ff) * (2*DT_W)'(dt_s1_ff);
   end

   // arithmetic shifts are the upper bits of each signed product
   always_ff @(posedge clock) begin
      if (!stl[1]) begin
         d1_s2_ff     <= d1_s1_ff;
         temp_part_ff <= prod_t[PROD_W-1:TEMP_SHIFT];
         off_part_ff  <= prod_off[PROD_W-1:OFF_SHIFT];
         sens_part_ff <= prod_sens[PROD_W-1:SENS_SHIFT];
         t2_ff        <= dt_sq[T2_SHIFT+T2_W-1:T2_SHIFT];
      end
   end

   always_comb begin
      fo_in.d1        = d1_s2_ff;
      fo_in.temp      = TEMPF_W'(temp_part_ff) + TEMPF_W'(TEMP_REF);
      fo_in.dev_ref   = TEMPF_W'(temp_part_ff);
      fo_in.dev_low   = DEVL_W'(temp_part_ff) + DEVL_W'(TEMP_REF - TEMP_LOW);
      fo_in.off       = OFF_W'($signed({1'b0, coef.pressure_offset, 16'h0000}))
                      + OFF_W'(off_part_ff);
      fo_in.sens      = SENS_W'($signed({1'b0, coef.pressure_sens, 15'h0000}))
                      + SENS_W'(sens_part_ff);
      fo_in.t2        = t2_ff;
      fo_in.below_ref = temp_part_ff < 0;
      fo_in.below_low = temp_part_ff < -(TEMP_REF - TEMP_LOW);
   end

   always_ff @(posedge clock) begin
      if (!stl[2]) begin
         fo_ff <= fo_in;
      end
   end

   assign in_stall  = stl[0];
   assign out_valid = vld_ff[2];
   assign out_data  = fo_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bptc_second_order.sv -----
`default_nettype none

module bptc_second_order import bptc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_stall,
   input  wire fo_type in_data,
   output logic        out_valid,
   input  wire logic   out_stall,
   output so_type      out_data
);

   logic [2:0] vld_ff, vld_in, vld_up;
   logic [3:0] stl;

   // stage 4: squared deviations, second-order temperature
   logic [RAW_W-1:0]         d1_s4_ff;
   logic signed [T_W-1:0]    t_s4_ff, t_s4_in;
   logic signed [OFF_W-1:0]  off_s4_ff;
   logic signed [SENS_W-1:0] sens_s4_ff;
   logic [SQ_W-1:0]          dsq_ff, esq_ff;
   logic                     below_ref_ff, below_low_ff;
   logic signed [2*TEMPF_W-1:0] dsq_full;
   logic signed [2*DEVL_W-1:0]  esq_full;
   logic [T2_W-1:0]          t2_sel;

   // stage 5: offset and sensitivity corrections
   logic [RAW_W-1:0]         d1_s5_ff;
   logic signed [T_W-1:0]    t_s5_ff;
   logic signed [OFF_W-1:0]  off_s5_ff;
   logic signed [SENS_W-1:0] sens_s5_ff;
   logic [CORR_W-1:0]        off2_ff, off2_in, sens2_ff, sens2_in;
   logic [CORR_W-1:0]        five_dsq, seven_esq, eleven_esq;

   // stage 6: corrected terms
   so_type so_ff, so_in;

   always_comb begin
      stl[3] = out_stall;
      stl[2] = vld_ff[2] & stl[3];
      stl[1] = vld_ff[1] & stl[2];
      stl[0] = vld_ff[0] & stl[1];
      vld_up = {vld_ff[1:0], in_valid};
      for (int k = 0; k < 3; k++) begin
         vld_in[k] = stl[k] ? vld_ff[k] : vld_up[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      dsq_full = (2*TEMPF_W)'(in_data.dev_ref) * (2*TEMPF_W)'(in_data.dev_ref);
      esq_full = (2*DEVL_W)'(in_data.dev_low) * (2*DEVL_W)'(in_data.dev_low);
      t2_sel   = in_data.below_ref ? in_data.t2 : '0;
      t_s4_in  = T_W'(in_data.temp) - T_W'($signed({1'b0, t2_sel}));
   end

   always_ff @(posedge clock) begin
      if (!stl[0]) begin
         d1_s4_ff     <= in_data.d1;
         t_s4_ff      <= t_s4_in;
         off_s4_ff    <= in_data.off;
         sens_s4_ff   <= in_data.sens;
         dsq_ff       <= dsq_full[SQ_W-1:0];
         esq_ff       <= esq_full[SQ_W-1:0];
         below_ref_ff <= in_data.below_ref;
         below_low_ff <= in_data.below_low;
      end
   end

   // small constant factors as shift-add, seven as shift-subtract
   always_comb begin
      five_dsq   = CORR_W'({dsq_ff, 2'b00}) + CORR_W'(dsq_ff);
      seven_esq  = CORR_W'({esq_ff, 3'b000}) - CORR_W'(esq_ff);
      eleven_esq = CORR_W'({esq_ff, 3'b000}) + CORR_W'({esq_ff, 1'b0}) + CORR_W'(esq_ff);
      off2_in    = '0;
      sens2_in   = '0;
      if (below_ref_ff) begin
         off2_in  = five_dsq >> 1;
         sens2_in = five_dsq >> 2;
      end
      if (below_low_ff) begin
         off2_in  = off2_in + seven_esq;
         sens2_in = sens2_in + (eleven_esq >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (!stl[1]) begin
         d1_s5_ff   <= d1_s4_ff;
         t_s5_ff    <= t_s4_ff;
         off_s5_ff  <= off_s4_ff;
         sens_s5_ff <= sens_s4_ff;
         off2_ff    <= off2_in;
         sens2_ff   <= sens2_in;
      end
   end

   always_comb begin
      so_in.d1     = d1_s5_ff;
      so_in.t      = t_s5_ff;
      so_in.off_c  = OFFC_W'(off_s5_ff) - OFFC_W'($signed({1'b0, off2_ff}));
      so_in.sens_c = SENSC_W'(sens_s5_ff) - SENSC_W'($signed({1'b0, sens2_ff}));
   end

   always_ff @(posedge clock) begin
      if (!stl[2]) begin
         so_ff <= so_in;
      end
   end

   assign in_stall  = stl[0];
   assign out_valid = vld_ff[2];
   assign out_data  = so_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bptc_pressure.sv -----
`default_nettype none

module bptc_pressure import bptc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_stall,
   input  wire so_type in_data,
   output logic        out_valid,
   input  wire logic   out_stall,
   output rsp_payload_type out_data
);

   logic [2:0] vld_ff, vld_in, vld_up;
   logic [3:0] stl;

   // stage 7: split product d1 * sens
   logic [PL_W-1:0]              pl_ff, pl_in;
   logic signed [PH_W-1:0]       ph_ff, ph_in;
   logic signed [OFFC_W-1:0]     off_c_s7_ff;
   logic signed [T_W-1:0]        t_s7_ff;
   logic signed [RAW_W:0]        d1_s;
   logic signed [SENSC_W-SPLIT_W-1:0] sens_hi;

   // stage 8: product shifted down, temperature clamp
   logic signed [Q_W-1:0]    q_ff, q_in;
   logic signed [OFFC_W-1:0] off_c_s8_ff;
   logic signed [TEMP_W-1:0] tc_ff, tc_in;
   logic                     t_flag_ff, t_flag_in;

   // stage 9: pressure and result register
   rsp_payload_type          rsp_ff, rsp_in;
   logic signed [X_W-1:0]    x_val;
   logic signed [P_W-1:0]    p_val;

   always_comb begin
      stl[3] = out_stall;
      stl[2] = vld_ff[2] & stl[3];
      stl[1] = vld_ff[1] & stl[2];
      stl[0] = vld_ff[0] & stl[1];
      vld_up = {vld_ff[1:0], in_valid};
      for (int k = 0; k < 3; k++) begin
         vld_in[k] = stl[k] ? vld_ff[k] : vld_up[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // low part unsigned, high part signed; the low split equals the shift by 21
   always_comb begin
      d1_s    = $signed({1'b0, in_data.d1});
      sens_hi = in_data.sens_c[SENSC_W-1:SPLIT_W];
      pl_in   = PL_W'(in_data.d1) * PL_W'(in_data.sens_c[SPLIT_W-1:0]);
      ph_in   = PH_W'(d1_s) * PH_W'(sens_hi);
   end

   always_ff @(posedge clock) begin
      if (!stl[0]) begin
         pl_ff       <= pl_in;
         ph_ff       <= ph_in;
         off_c_s7_ff <= in_data.off_c;
         t_s7_ff     <= in_data.t;
      end
   end

   always_comb begin
      q_in      = Q_W'(ph_ff) + Q_W'($signed({1'b0, pl_ff[PL_W-1:SPLIT_W]}));
      tc_in     = TEMP_W'(t_s7_ff);
      t_flag_in = 1'b0;
      if (t_s7_ff < T_MIN) begin
         tc_in     = TEMP_W'(T_MIN);
         t_flag_in = 1'b1;
      end
      if (t_s7_ff > T_MAX) begin
         tc_in     = TEMP_W'(T_MAX);
         t_flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!stl[1]) begin
         q_ff        <= q_in;
         off_c_s8_ff <= off_c_s7_ff;
         tc_ff       <= tc_in;
         t_flag_ff   <= t_flag_in;
      end
   end

   always_comb begin
      x_val               = X_W'(q_ff) - X_W'(off_c_s8_ff);
      p_val               = x_val[X_W-1:P_OUT_SHIFT];
      rsp_in.temperature  = tc_ff;
      rsp_in.pressure     = p_val[PRES_W-1:0];
      rsp_in.out_of_range = t_flag_ff;
      if (p_val < P_MIN) begin
         rsp_in.pressure     = PRES_W'(P_MIN);
         rsp_in.out_of_range = 1'b1;
      end
      if (p_val > P_MAX) begin
         rsp_in.pressure     = PRES_W'(P_MAX);
         rsp_in.out_of_range = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!stl[2]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign in_stall  = stl[0];
   assign out_valid = vld_ff[2];
   assign out_data  = rsp_ff;

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (rsp_ff.temperature >= T_MIN) && (rsp_ff.temperature <= T_MAX)
                 && (rsp_ff.pressure >= P_MIN) && (rsp_ff.pressure <= P_MAX))
      else $error("result outside clamp range");

   a_split_stage_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && stl[1] |=> vld_ff[0] && $stable(pl_ff) && $stable(ph_ff))
      else $error("partial products changed while stalled");

   a_result_from_prior: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff[2]) |-> $past(vld_ff[1]))
      else $error("result valid without an item in the previous stage");

   a_flag_on_clamp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] && !stl[2] && (p_val < P_MIN || p_val > P_MAX)
         |=> rsp_ff.out_of_range)
      else $error("pressure clamp not flagged");

endmodule

`default_nettype wire

// ----- rtl/core/baro_pressure_temp_compensation.sv -----
// throughput: one item per cycle while rsp_stall is low; nine register stages,
// each holding its item only while the stage after it is full and stalled
// coefficient registers reset to zero and are written through the csr port
// reset clears every stage valid bit; no clearing pass, ready right after reset
`default_nettype none

module baro_pressure_temp_compensation import bptc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_payload,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]      csr_wdata
);

   coef_type coef;
   fo_type   fo_data;
   so_type   so_data;
   logic     fo_valid, fo_stall, so_valid, so_stall;

   bptc_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   bptc_first_order u_first_order (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_payload),
      .coef      (coef),
      .out_valid (fo_valid),
      .out_stall (fo_stall),
      .out_data  (fo_data)
   );

   bptc_second_order u_second_order (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fo_valid),
      .in_stall  (fo_stall),
      .in_data   (fo_data),
      .out_valid (so_valid),
      .out_stall (so_stall),
      .out_data  (so_data)
   );

   bptc_pressure u_pressure (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (so_valid),
      .in_stall  (so_stall),
      .in_data   (so_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- dv/baro_pressure_temp_compensation_tb.sv -----
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_tb;
   import bptc_pkg::*;

   localparam int LATENCY         = 9;
   localparam int RESET_CYCLES    = 5;
   localparam int IDLE_PCT        = 15;
   localparam int LONG_HOLD       = 300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 280;
   localparam int HOLD_PHASE      = 1;
   localparam int QUIET_PHASE     = 4;
   localparam int PRINT_CAP       = 100;
   localparam longint RAW_MAX     = (longint'(1) <<< RAW_W) - 1;

   // indexes past the last coefficient, writes there must not land anywhere
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_0 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_1 = 3'd7;

   localparam logic [RAW_W-1:0] TYPICAL_D1 = 24'd9085466;
   localparam coef_type TYPICAL_COEFS =
      {16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
   localparam coef_type ALL_ONES_COEFS = '1;
   localparam coef_type MIXED_COEFS =
      {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]      csr_wdata = '0;

   req_payload_type reading_q[$];
   rsp_payload_type compensated_q[$];
   coef_type        coef_model = '0;
   int              mismatch_cnt = 0;
   int              cycle_cnt = 0;
   int              hold_cnt = 0;
   int              long_hold_req = 0;
   int              long_hold_ack = 0;
   bit              no_idle = 1'b0;

   baro_pressure_temp_compensation i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // first- and second-order compensation on 64-bit signed intermediates
   function automatic rsp_payload_type compensate(input coef_type c, input req_payload_type r);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, off2, sens2, dev, t, p;
      logic flag;
      rsp_payload_type res;
      d1 = r.pressure_raw;
      d2 = r.temperature_raw;
      c1 = c.pressure_sens;
      c2 = c.pressure_offset;
      c3 = c.tcs;
      c4 = c.tco;
      c5 = c.tref;
      c6 = c.tempsens;
      dt   = d2 - c5 * 256;
      temp = TEMP_REF + ((dt * c6) >>> TEMP_SHIFT);
      off  = c2 * 65536 + ((c4 * dt) >>> OFF_SHIFT);
      sens = c1 * 32768 + ((c3 * dt) >>> SENS_SHIFT);
      t2    = 0;
      off2  = 0;
      sens2 = 0;
      // both thresholds look at the first-order temperature
      if (temp < TEMP_REF) begin
         dev   = temp - TEMP_REF;
         t2    = (dt * dt) >>> T2_SHIFT;
         off2  = (5 * dev * dev) >>> 1;
         sens2 = (5 * dev * dev) >>> 2;
      end
      if (temp < TEMP_LOW) begin
         dev   = temp - TEMP_LOW;
         off2  = off2 + 7 * dev * dev;
         sens2 = sens2 + ((11 * dev * dev) >>> 1);
      end
      t = temp - t2;
      p = (((d1 * (sens - sens2)) >>> 21) - (off - off2)) >>> P_OUT_SHIFT;
      flag = 1'b0;
      if (t < T_MIN) begin
         t = T_MIN;
         flag = 1'b1;
      end
      if (t > T_MAX) begin
         t = T_MAX;
         flag = 1'b1;
      end
      if (p < P_MIN) begin
         p = P_MIN;
         flag = 1'b1;
      end
      if (p > P_MAX) begin
         p = P_MAX;
         flag = 1'b1;
      end
      res.temperature  = t[TEMP_W-1:0];
      res.pressure     = p[PRES_W-1:0];
      res.out_of_range = flag;
      return res;
   endfunction

   // smallest raw temperature whose first-order temperature reaches target
   function automatic logic [RAW_W-1:0] d2_for_temp(input coef_type c, input longint target);
      longint num, c6, dt, d2;
      c6  = c.tempsens;
      num = (target - TEMP_REF) <<< TEMP_SHIFT;
      if (num >= 0) begin
         dt = (num + c6 - 1) / c6;
      end else begin
         dt = -((-num) / c6);
      end
      d2 = longint'(c.tref) * 256 + dt;
      if (d2 < 0) begin
         d2 = 0;
      end else if (d2 > RAW_MAX) begin
         d2 = RAW_MAX;
      end
      return d2[RAW_W-1:0];
   endfunction

   // mostly plausible sensor readings, the rest anywhere in the raw range
   function automatic req_payload_type random_reading(input coef_type c);
      req_payload_type r;
      longint d2;
      r.pressure_raw    = RAW_W'($urandom);
      r.temperature_raw = RAW_W'($urandom);
      if ($urandom_range(99) < 65) begin
         d2 = longint'(c.tref) * 256 + longint'($urandom_range(4000000)) - 2000000;
         if (d2 < 0) begin
            d2 = 0;
         end else if (d2 > RAW_MAX) begin
            d2 = RAW_MAX;
         end
         r.temperature_raw = d2[RAW_W-1:0];
         r.pressure_raw    = RAW_W'($urandom_range(12000000, 4000000));
      end
      return r;
   endfunction

   function automatic coef_type random_coefs(input bit near_typical);
      coef_type c;
      logic [COEF_W-1:0] word;
      c = TYPICAL_COEFS;
      for (int i = 0; i < 6; i++) begin
         word = c[i*COEF_W +: COEF_W];
         if (near_typical) begin
            word = word + COEF_W'($urandom_range(8000)) - 16'd4000;
         end else begin
            word = COEF_W'($urandom);
         end
         c[i*COEF_W +: COEF_W] = word;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_cnt < PRINT_CAP) begin
         $display("%0t: %s", $time, msg);
      end
      mismatch_cnt++;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [COEF_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_PRESSURE_SENS:   coef_model.pressure_sens   = data;
         CSR_PRESSURE_OFFSET: coef_model.pressure_offset = data;
         CSR_TCS:             coef_model.tcs             = data;
         CSR_TCO:             coef_model.tco             = data;
         CSR_TREF:            coef_model.tref            = data;
         CSR_TEMPSENS:        coef_model.tempsens        = data;
         default: ;
      endcase
   endtask

   task automatic load_coefs(input coef_type c);
      csr_write(CSR_PRESSURE_SENS, c.pressure_sens);
      csr_write(CSR_PRESSURE_OFFSET, c.pressure_offset);
      csr_write(CSR_TCS, c.tcs);
      csr_write(CSR_TCO, c.tco);
      csr_write(CSR_TREF, c.tref);
      csr_write(CSR_TEMPSENS, c.tempsens);
      csr_write(CSR_SPARE_0, COEF_W'($urandom));
      csr_write(CSR_SPARE_1, COEF_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      req_payload_type r;
      r.pressure_raw    = d1;
      r.temperature_raw = d2;
      reading_q.push_back(r);
   endtask

   task automatic queue_corners();
      queue_reading('0, '0);
      queue_reading('0, '1);
      queue_reading('1, '0);
      queue_reading('1, '1);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (reading_q.size() != 0 || req_valid || compensated_q.size() != 0);
   endtask

   // input side: offer queued readings, hold the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            compensated_q.push_back(compensate(coef_model, req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (reading_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_payload <= reading_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (long_hold_req != long_hold_ack) begin
         long_hold_ack <= long_hold_req;
         hold_cnt      <= LONG_HOLD;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (compensated_q.size() == 0) begin
            report_mismatch("result transfer with no reading outstanding");
         end else begin
            want = compensated_q.pop_front();
            if (rsp_payload.temperature !== want.temperature) begin
               report_mismatch($sformatf("temperature %0d, expected %0d",
                  $signed(rsp_payload.temperature), $signed(want.temperature)));
            end
            if (rsp_payload.pressure !== want.pressure) begin
               report_mismatch($sformatf("pressure %0d, expected %0d",
                  rsp_payload.pressure, want.pressure));
            end
            if (rsp_payload.out_of_range !== want.out_of_range) begin
               report_mismatch($sformatf("out_of_range %0b, expected %0b",
                  rsp_payload.out_of_range, want.out_of_range));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      coef_type   c;
      logic [RAW_W-1:0] d2_ref;
      logic [RAW_W-1:0] d2_low;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // coefficients still at their zero reset value
      queue_corners();
      drain();

      load_coefs(TYPICAL_COEFS);
      d2_ref = d2_for_temp(TYPICAL_COEFS, TEMP_REF);
      d2_low = d2_for_temp(TYPICAL_COEFS, TEMP_LOW);
      queue_reading(TYPICAL_D1, d2_ref);
      queue_reading(TYPICAL_D1, d2_ref - 1'b1);
      queue_reading(TYPICAL_D1, d2_low);
      queue_reading(TYPICAL_D1, d2_low - 1'b1);
      queue_reading(TYPICAL_D1, 24'd8569150);
      queue_corners();
      drain();

      load_coefs(ALL_ONES_COEFS);
      queue_corners();
      drain();

      load_coefs(MIXED_COEFS);
      queue_corners();
      drain();

      load_coefs(~MIXED_COEFS);
      queue_corners();
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 3)
            0:       c = TYPICAL_COEFS;
            1:       c = random_coefs(1'b1);
            default: c = random_coefs(1'b0);
         endcase
         load_coefs(c);
         if (ph == QUIET_PHASE) begin
            no_idle = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            reading_q.push_back(random_reading(c));
         end
         // stall the result side long enough that the pipeline backs up
         if (ph == HOLD_PHASE) begin
            long_hold_req++;
         end
         drain();
         no_idle = 1'b0;
      end

      repeat (2 * LATENCY) @(negedge clock);
      if (mismatch_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/bptc_pkg.sv
rtl/core/bptc_coef_regs.sv
rtl/core/bptc_first_order.sv
rtl/core/bptc_second_order.sv
rtl/core/bptc_pressure.sv
rtl/core/baro_pressure_temp_compensation.sv
dv/baro_pressure_temp_compensation_tb.sv
